>>> design/esc_pkg.sv
// Shared types, constants and helpers for the environmental sensor compensation core.
// No dependencies; imported by every module in this folder.

package esc_pkg;

	localparam int DIV_BITS   = 64;
	localparam int PRE_STAGES = 4;
	localparam int POST_STAGES = 5;
	// abs stage + one stage per quotient bit + sign fix stage
	localparam int DIV_LAT    = DIV_BITS + 2;
	localparam int PRESS_LAT  = PRE_STAGES + DIV_LAT + POST_STAGES;
	localparam int HUM_LAT    = 7;
	localparam int HUM_PAD    = PRESS_LAT - HUM_LAT;

	localparam logic [2:0] REG_TEMP    = 3'd0;
	localparam logic [2:0] REG_PRESS_A = 3'd1;
	localparam logic [2:0] REG_PRESS_B = 3'd2;
	localparam logic [2:0] REG_PRESS_C = 3'd3;
	localparam logic [2:0] REG_HUM_A   = 3'd4;
	localparam logic [2:0] REG_HUM_B   = 3'd5;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic [13:0]        humidity_centi;
		logic               pressure_div_zero;
	} result_t;

	typedef struct packed {
		logic [15:0] t1, t2, t3;
		logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [15:0] h4, h5;
		logic [7:0]  h6;
	} coeffs_t;

	function automatic logic [31:0] sx32_16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx32_8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
		return 64'($signed(v) >>> n);
	endfunction

	function automatic coeffs_t unpack_coeffs(
		input logic [47:0] tc, input logic [47:0] pa, input logic [47:0] pb,
		input logic [47:0] pc, input logic [31:0] ha, input logic [39:0] hb);
		coeffs_t c;
		c.t1 = tc[15:0];  c.t2 = tc[31:16]; c.t3 = tc[47:32];
		c.p1 = pa[15:0];  c.p2 = pa[31:16]; c.p3 = pa[47:32];
		c.p4 = pb[15:0];  c.p5 = pb[31:16]; c.p6 = pb[47:32];
		c.p7 = pc[15:0];  c.p8 = pc[31:16]; c.p9 = pc[47:32];
		c.h1 = ha[7:0];   c.h2 = ha[23:8];  c.h3 = ha[31:24];
		c.h4 = hb[15:0];  c.h5 = hb[31:16]; c.h6 = hb[39:32];
		return c;
	endfunction

	// temperature in 0.01 degC from the fine temperature
	function automatic logic [31:0] temp_from_fine(input logic [31:0] tf);
		logic [31:0] t5;
		t5 = {tf[29:0], 2'b00} + tf;
		return sra32(t5 + 32'd128, 8);
	endfunction

endpackage

>>> design/env_sensor_compensation_core.sv
// Top level of the environmental sensor compensation core: coefficient registers,
// fine temperature, pressure and humidity pipelines, result alignment.
// Depends on esc_pkg, esc_temp, esc_hum, esc_press.

// The core takes one raw sample set on every clock cycle (busy never rises) and
// returns each result after the temperature and pressure pipelines, marked by a
// one-cycle done strobe; results cannot be held off. The pipeline depth is set mostly
// by the 64-stage restoring divider in the pressure path, one quotient bit per stage.
// Coefficient registers are written through cfg_we/cfg_index/cfg_wdata and must
// only change while no sample is in flight; indexes 6 and 7 are ignored.

module env_sensor_compensation_core import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sample_t     sample,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);

	logic [47:0] temp_c_q, press_a_q, press_b_q, press_c_q;
	logic [31:0] hum_a_q;
	logic [39:0] hum_b_q;
	coeffs_t     coeffs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_c_q  <= '0;
			press_a_q <= '0;
			press_b_q <= '0;
			press_c_q <= '0;
			hum_a_q   <= '0;
			hum_b_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP:    temp_c_q  <= cfg_wdata;
				REG_PRESS_A: press_a_q <= cfg_wdata;
				REG_PRESS_B: press_b_q <= cfg_wdata;
				REG_PRESS_C: press_c_q <= cfg_wdata;
				REG_HUM_A:   hum_a_q   <= cfg_wdata[31:0];
				REG_HUM_B:   hum_b_q   <= cfg_wdata[39:0];
				default: ;
			endcase
		end
	end

	assign coeffs = unpack_coeffs(temp_c_q, press_a_q, press_b_q, press_c_q,
		hum_a_q, hum_b_q);

	assign busy = 1'b0;

	logic        tv;
	logic [31:0] tf;
	logic [19:0] rp;
	logic [15:0] rh;

	esc_temp u_temp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.in_sample(sample),
		.coeffs   (coeffs),
		.out_valid(tv),
		.fine     (tf),
		.raw_p    (rp),
		.raw_h    (rh)
	);

	logic        hv;
	logic [13:0] hum;

	esc_hum u_hum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tv),
		.fine     (tf),
		.raw_h    (rh),
		.coeffs   (coeffs),
		.out_valid(hv),
		.hum      (hum)
	);

	logic        pv;
	logic [31:0] press;
	logic        dz;

	esc_press u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tv),
		.fine     (tf),
		.raw_p    (rp),
		.coeffs   (coeffs),
		.out_valid(pv),
		.press    (press),
		.div_zero (dz)
	);

	// align temperature and humidity with the pressure path; every stage shifts each cycle
	logic [31:0] temp_dly_q [PRESS_LAT];
	logic [13:0] hum_dly_q  [HUM_PAD];
	logic        hum_v_q;

	always_ff @(posedge clk) begin
		temp_dly_q[0] <= temp_from_fine(tf);
		for (int i = 1; i < PRESS_LAT; i++)
			temp_dly_q[i] <= temp_dly_q[i-1];
		hum_dly_q[0] <= hum;
		for (int i = 1; i < HUM_PAD; i++)
			hum_dly_q[i] <= hum_dly_q[i-1];
	end

	// humidity valid is implied by pressure valid; registered but masked out of div_zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hum_v_q <= 1'b0;
		else
			hum_v_q <= hv;
	end

	assign done                     = pv;
	assign result.temperature_centi = temp_dly_q[PRESS_LAT-1];
	assign result.pressure_pa       = press;
	assign result.humidity_centi    = hum_dly_q[HUM_PAD-1];
	assign result.pressure_div_zero = dz | (hum_v_q & 1'b0);

endmodule

>>> design/esc_temp.sv
// Fine temperature pipeline, three stages.
// Depends on esc_pkg.

module esc_temp import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  sample_t     in_sample,
	input  coeffs_t     coeffs,
	output logic        out_valid,
	output logic [31:0] fine,
	output logic [19:0] raw_p,
	output logic [15:0] raw_h
);

	logic        v_s1, v_s2, v_s3;
	logic [31:0] v1_s1, dd_s1, v1_s2, m_s2, tf_s3;
	logic [19:0] rp_s1, rp_s2, rp_s3;
	logic [15:0] rh_s1, rh_s2, rh_s3;
	logic [31:0] a, d, at, dd, m;

	always_comb begin
		a  = {15'd0, in_sample.raw_temperature[19:3]} - {15'd0, coeffs.t1, 1'b0};
		d  = {16'd0, in_sample.raw_temperature[19:4]} - {16'd0, coeffs.t1};
		at = a * sx32_16(coeffs.t2);
		dd = d * d;
		m  = sra32(dd_s1, 12) * sx32_16(coeffs.t3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		v1_s1 <= sra32(at, 11);
		dd_s1 <= dd;
		rp_s1 <= in_sample.raw_pressure;
		rh_s1 <= in_sample.raw_humidity;
		v1_s2 <= v1_s1;
		m_s2  <= m;
		rp_s2 <= rp_s1;
		rh_s2 <= rh_s1;
		tf_s3 <= v1_s2 + sra32(m_s2, 14);
		rp_s3 <= rp_s2;
		rh_s3 <= rh_s2;
	end

	assign out_valid = v_s3;
	assign fine      = tf_s3;
	assign raw_p     = rp_s3;
	assign raw_h     = rh_s3;

endmodule

>>> design/esc_hum.sv
// Humidity compensation pipeline, seven stages, one multiply level per stage.
// Depends on esc_pkg.

module esc_hum import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] fine,
	input  logic [15:0] raw_h,
	input  coeffs_t     coeffs,
	output logic        out_valid,
	output logic [13:0] hum
);

	logic [HUM_LAT-1:0] v_q;
	logic [31:0] a_s1, b_s1, c_s1, a_s2, e_s2, a_s3, f_s3, x_s4;
	logic [31:0] dd_s5, x_s5, m_s6, x_s6;
	logic [13:0] hum_s7;
	logic [31:0] x, a0, b0, c0, bc, ef, xf, d, dd, m, xr, xc;
	logic [23:0] scaled;

	always_comb begin
		x  = fine - 32'd76800;
		a0 = {2'b00, raw_h, 14'd0} - {coeffs.h4[11:0], 20'd0} - sx32_16(coeffs.h5) * x;
		b0 = x * sx32_8(coeffs.h6);
		c0 = x * {24'd0, coeffs.h3};
		bc = b_s1 * c_s1;
		ef = e_s2 * sx32_16(coeffs.h2);
		xf = a_s3 * f_s3;
		d  = sra32(x_s4, 15);
		dd = d * d;
		m  = sra32(dd_s5, 7) * {24'd0, coeffs.h1};
		xr = x_s6 - sra32(m_s6, 4);
		if (xr[31])
			xc = 32'd0;
		else if (xr > 32'd419430400)
			xc = 32'd419430400;
		else
			xc = xr;
		scaled = 24'(xc[28:12]) * 24'd100;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else
			v_q <= {v_q[HUM_LAT-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		a_s1   <= sra32(a0 + 32'd16384, 15);
		b_s1   <= sra32(b0, 10);
		c_s1   <= sra32(c0, 11) + 32'd32768;
		a_s2   <= a_s1;
		e_s2   <= sra32(bc, 10) + 32'd2097152;
		a_s3   <= a_s2;
		f_s3   <= sra32(ef + 32'd8192, 14);
		x_s4   <= xf;
		dd_s5  <= dd;
		x_s5   <= x_s4;
		m_s6   <= m;
		x_s6   <= x_s5;
		hum_s7 <= scaled[23:10];
	end

	assign out_valid = v_q[HUM_LAT-1];
	assign hum       = hum_s7;

endmodule

>>> design/esc_sdiv.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
// Depends on esc_pkg.

module esc_sdiv import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic        tag_in,
	output logic        out_valid,
	output logic [63:0] quot,
	output logic        tag_out
);

	// {remainder, numerator/quotient} per stage
	logic [127:0] rq_s  [DIV_BITS+1];
	logic [63:0]  d_s   [DIV_BITS+1];
	logic         neg_s [DIV_BITS+1];
	logic         tag_s [DIV_BITS+1];
	logic         v_s   [DIV_BITS+1];
	logic [63:0]  q_out_q;
	logic         v_out_q, tag_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		rq_s[0]  <= {64'd0, num[63] ? (64'd0 - num) : num};
		d_s[0]   <= den[63] ? (64'd0 - den) : den;
		neg_s[0] <= num[63] ^ den[63];
		tag_s[0] <= tag_in;
	end

	for (genvar i = 1; i <= DIV_BITS; i++) begin : g_bit
		logic [64:0] sh, tr;

		always_comb begin
			sh = rq_s[i-1][127:63];
			tr = sh - {1'b0, d_s[i-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else
				v_s[i] <= v_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (!tr[64])
				rq_s[i] <= {tr[63:0], rq_s[i-1][62:0], 1'b1};
			else
				rq_s[i] <= {sh[63:0], rq_s[i-1][62:0], 1'b0};
			d_s[i]   <= d_s[i-1];
			neg_s[i] <= neg_s[i-1];
			tag_s[i] <= tag_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out_q <= 1'b0;
		else
			v_out_q <= v_s[DIV_BITS];
	end

	always_ff @(posedge clk) begin
		q_out_q   <= neg_s[DIV_BITS] ? (64'd0 - rq_s[DIV_BITS][63:0]) : rq_s[DIV_BITS][63:0];
		tag_out_q <= tag_s[DIV_BITS];
	end

	assign out_valid = v_out_q;
	assign quot      = q_out_q;
	assign tag_out   = tag_out_q;

endmodule

>>> design/esc_press.sv
// Pressure compensation: 64-bit pre-division stages, divider, post-division stages.
// Depends on esc_pkg and esc_sdiv.

module esc_press import esc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] fine,
	input  logic [19:0] raw_p,
	input  coeffs_t     coeffs,
	output logic        out_valid,
	output logic [31:0] press,
	output logic        div_zero
);

	// pre-division
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [63:0] sq_s1, t5_s1, t2_s1, a6_s2, a3_s2, t5_s2, t2_s2;
	logic [63:0] q2_s3, q1_s3, m_s4, num_s4;
	logic [19:0] rp_s1, rp_s2, rp_s3;

	logic signed [33:0] q1w;
	logic signed [67:0] sqw;
	logic signed [49:0] t5w, t2w;
	logic signed [79:0] a6w, a3w;
	logic signed [80:0] mw;
	logic [63:0] base, pnum, den;

	always_comb begin
		q1w  = $signed({{2{fine[31]}}, fine}) - 34'sd128000;
		sqw  = q1w * q1w;
		t5w  = q1w * $signed(coeffs.p5);
		t2w  = q1w * $signed(coeffs.p2);
		a6w  = $signed(sq_s1) * $signed(coeffs.p6);
		a3w  = $signed(sq_s1) * $signed(coeffs.p3);
		base = 64'h0000_8000_0000_0000 + q1_s3;
		mw   = $signed(base) * $signed({1'b0, coeffs.p1});
		pnum = {12'd0, 21'(21'h100000 - {1'b0, rp_s3}), 31'd0} - q2_s3;
		den  = sra64(m_s4, 33);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1  <= sqw[63:0];
		t5_s1  <= {{14{t5w[49]}}, t5w};
		t2_s1  <= {{14{t2w[49]}}, t2w};
		rp_s1  <= raw_p;
		a6_s2  <= a6w[63:0];
		a3_s2  <= a3w[63:0];
		t5_s2  <= t5_s1;
		t2_s2  <= t2_s1;
		rp_s2  <= rp_s1;
		q2_s3  <= a6_s2 + {t5_s2[46:0], 17'd0} + {{13{coeffs.p4[15]}}, coeffs.p4, 35'd0};
		q1_s3  <= sra64(a3_s2, 8) + {t2_s2[51:0], 12'd0};
		rp_s3  <= rp_s2;
		m_s4   <= mw[63:0];
		num_s4 <= pnum * 64'd3125;
	end

	logic        dv;
	logic [63:0] dq;
	logic        dz;

	esc_sdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.num      (num_s4),
		.den      (den),
		.tag_in   (den == 64'd0),
		.out_valid(dv),
		.quot     (dq),
		.tag_out  (dz)
	);

	// post-division
	logic        v_s5, v_s6, v_s7, v_s8, v_s9;
	logic        dz_s5, dz_s6, dz_s7, dz_s8, dz_s9;
	logic [63:0] p_s5, ps_s5, m1_s5, m8_s5;
	logic [63:0] p_s6, m8_s6, pp0_s6, p_s7, m8_s7, m2_s7, sum_s8;
	logic [31:0] pp1_s6, pp2_s6, press_s9;

	logic signed [79:0] m1w, m8w;
	logic [63:0] ps, pp0, pp, adj;
	logic [31:0] pp1, pp2;

	always_comb begin
		ps  = sra64(dq, 13);
		m1w = $signed(ps) * $signed(coeffs.p9);
		m8w = $signed(dq) * $signed(coeffs.p8);
		// low 64 bits of m1 * ps from 32-bit partial products
		pp0 = m1_s5[31:0] * ps_s5[31:0];
		pp1 = m1_s5[31:0] * ps_s5[63:32];
		pp2 = m1_s5[63:32] * ps_s5[31:0];
		pp  = sra64(sum_s8, 8) + {{44{coeffs.p7[15]}}, coeffs.p7, 4'd0};
		adj = pp + (pp[63] ? 64'd255 : 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s5 <= dv;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		p_s5     <= dq;
		ps_s5    <= ps;
		m1_s5    <= m1w[63:0];
		m8_s5    <= m8w[63:0];
		dz_s5    <= dz;
		p_s6     <= p_s5;
		m8_s6    <= m8_s5;
		pp0_s6   <= pp0;
		pp1_s6   <= pp1;
		pp2_s6   <= pp2;
		dz_s6    <= dz_s5;
		p_s7     <= p_s6;
		m8_s7    <= m8_s6;
		m2_s7    <= pp0_s6 + {pp1_s6 + pp2_s6, 32'd0};
		dz_s7    <= dz_s6;
		sum_s8   <= p_s7 + sra64(m2_s7, 25) + sra64(m8_s7, 19);
		dz_s8    <= dz_s7;
		press_s9 <= dz_s8 ? 32'd0 : adj[39:8];
		dz_s9    <= dz_s8;
	end

	assign out_valid = v_s9;
	assign press     = press_s9;
	assign div_zero  = dz_s9;

endmodule
